>>> rtl/core/dtw_pkg.sv
package dtw_pkg;

  // Field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WORD_W   = 32;
  // Decoded length holds up to 2^32 (saturated), so one bit above a word
  localparam int unsigned ACC_W    = WORD_W + 1;
  localparam int unsigned STATUS_W = 3;

  // Default maximum number of long-form length octets
  localparam int unsigned MAX_LENGTH_OCTETS_DEF = 4;

  // Identifier and length octet codes
  localparam logic [4:0] TAG_NUM_HIGH  = 5'h1F;  // low five bits all set: high tag form
  localparam int unsigned LEN_CNT_W    = 7;      // length octet count in long form
  localparam logic [ACC_W-1:0] ACC_SAT = {1'b1, {WORD_W{1'b0}}};

  // Stream packing
  localparam int unsigned S_TDATA_W = BYTE_W;
  localparam int unsigned M_TDATA_W = 72;  // 8 + 32 + 32 bits, whole bytes

  typedef enum logic [1:0] {
    PH_TAG,
    PH_LEN,
    PH_LENOCT,
    PH_CONTENT
  } phase_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_HIGHTAG = 3'd1,
    ST_INDEF   = 3'd2,
    ST_TOOLONG = 3'd3,
    ST_OVERRUN = 3'd4
  } status_e;

  // Walker state, except the length octet counter whose width is a parameter
  typedef struct packed {
    phase_e             phase;
    logic [WORD_W-1:0]  byte_pos;
    logic [WORD_W-1:0]  bytes_rem;
    logic [ACC_W-1:0]   accum;
    logic [BYTE_W-1:0]  held_tag;
    logic [WORD_W-1:0]  skip_left;
    logic               err;
  } walk_state_t;

  // One result of a processed byte
  typedef struct packed {
    logic               valid;
    logic [BYTE_W-1:0]  tag;
    logic [WORD_W-1:0]  length;
    logic [WORD_W-1:0]  offset;
    status_e            status;
    logic               done;
  } walk_result_t;

endpackage

>>> rtl/core/dtw_step.sv
module dtw_step
  import dtw_pkg::*;
#(
  parameter int unsigned MAX_LENGTH_OCTETS = MAX_LENGTH_OCTETS_DEF,
  parameter int unsigned LL_W = $clog2(MAX_LENGTH_OCTETS + 1)
) (
  input  walk_state_t        state_i,
  input  logic [LL_W-1:0]    len_left_i,
  input  logic [WORD_W-1:0]  region_length_i,
  input  logic [BYTE_W-1:0]  data_byte_i,
  input  logic               region_start_i,
  output walk_state_t        state_o,
  output logic [LL_W-1:0]    len_left_o,
  output walk_result_t       result_o
);

  localparam logic [LEN_CNT_W-1:0] MaxCnt = LEN_CNT_W'(MAX_LENGTH_OCTETS);

  walk_state_t          s;
  logic [LL_W-1:0]      ll;
  logic [WORD_W-1:0]    left;
  logic [LEN_CNT_W-1:0] cnt;
  logic [ACC_W-1:0]     acc_shift;
  logic [ACC_W-1:0]     fin_len;
  logic                 do_fin;

  // Region start clears the walk before the byte is looked at
  always_comb begin
    s  = state_i;
    ll = len_left_i;
    if (region_start_i) begin
      s.err       = 1'b0;
      s.byte_pos  = '0;
      s.bytes_rem = region_length_i;
      s.phase     = PH_TAG;
      s.accum     = '0;
      s.skip_left = '0;
      ll          = '0;
    end
  end

  assign left = s.bytes_rem - WORD_W'(1);
  assign cnt  = data_byte_i[LEN_CNT_W-1:0];

  // Next long-form accumulator, saturating at 2^32
  assign acc_shift = (s.accum[ACC_W-1:WORD_W-BYTE_W] != '0) ? ACC_SAT
                   : {1'b0, s.accum[WORD_W-BYTE_W-1:0], data_byte_i};

  // Per-byte parse
  always_comb begin
    state_o    = s;
    len_left_o = ll;
    result_o   = '0;
    result_o.status = ST_OK;
    do_fin     = 1'b0;
    fin_len    = s.accum;

    if (!s.err && s.bytes_rem != '0) begin
      unique case (s.phase)
        PH_TAG: begin
          state_o.held_tag = data_byte_i;
          if (data_byte_i[4:0] == TAG_NUM_HIGH) begin
            result_o.valid  = 1'b1;
            result_o.tag    = data_byte_i;
            result_o.status = ST_HIGHTAG;
            state_o.err     = 1'b1;
          end else if (left == '0) begin
            result_o.valid  = 1'b1;
            result_o.tag    = data_byte_i;
            result_o.status = ST_OVERRUN;
            state_o.err     = 1'b1;
          end else begin
            state_o.phase = PH_LEN;
          end
        end
        PH_LEN: begin
          if (!data_byte_i[BYTE_W-1]) begin
            // short form
            fin_len       = ACC_W'(data_byte_i);
            state_o.accum = fin_len;
            do_fin        = 1'b1;
          end else if (cnt == '0) begin
            result_o.valid  = 1'b1;
            result_o.tag    = s.held_tag;
            result_o.status = ST_INDEF;
            state_o.err     = 1'b1;
          end else if (cnt > MaxCnt) begin
            result_o.valid  = 1'b1;
            result_o.tag    = s.held_tag;
            result_o.status = ST_TOOLONG;
            state_o.err     = 1'b1;
          end else if (left < WORD_W'(cnt)) begin
            result_o.valid  = 1'b1;
            result_o.tag    = s.held_tag;
            result_o.status = ST_OVERRUN;
            state_o.err     = 1'b1;
          end else begin
            len_left_o    = LL_W'(cnt);
            state_o.accum = '0;
            state_o.phase = PH_LENOCT;
          end
        end
        PH_LENOCT: begin
          fin_len       = acc_shift;
          state_o.accum = acc_shift;
          len_left_o    = ll - LL_W'(1);
          do_fin        = (len_left_o == '0);
        end
        PH_CONTENT: begin
          state_o.skip_left = s.skip_left - WORD_W'(1);
          if (state_o.skip_left == '0) begin
            state_o.phase = PH_TAG;
          end
        end
        default: ;
      endcase

      // Header complete: check the content against what is left
      if (do_fin) begin
        if (fin_len > {1'b0, left}) begin
          result_o.valid  = 1'b1;
          result_o.tag    = s.held_tag;
          result_o.status = ST_OVERRUN;
          state_o.err     = 1'b1;
        end else begin
          result_o.valid    = 1'b1;
          result_o.tag      = s.held_tag;
          result_o.length   = fin_len[WORD_W-1:0];
          result_o.offset   = s.byte_pos + WORD_W'(1);
          result_o.status   = ST_OK;
          result_o.done     = (fin_len == {1'b0, left});
          state_o.skip_left = fin_len[WORD_W-1:0];
          state_o.phase     = (fin_len == '0) ? PH_TAG : PH_CONTENT;
        end
      end

      state_o.bytes_rem = left;
      state_o.byte_pos  = s.byte_pos + WORD_W'(1);
    end
  end

endmodule

>>> rtl/core/der_tlv_header_walker_unit.sv
// Channel   | Dir | tdata (low bit up)                      | tuser         | tlast
// s_axis    | in  | data_byte[7:0]                          | region_start  | -
// m_axis    | out | tag_octet, content_length, content_off. | status[2:0]   | region_done
// cfg       | in  | region_length[31:0] on cfg_we_i         | -             | -
//
// One byte per cycle sustained while results are taken; a byte passes the
// input register, then the result register.
// The whole per-byte parse sits between the input register and the result register.
// Reset clears the walk state, region length and both valid flags.
// A full result register that is not taken stalls the byte in the input register.
module der_tlv_header_walker_unit
  import dtw_pkg::*;
#(
  parameter int unsigned MAX_LENGTH_OCTETS = MAX_LENGTH_OCTETS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [WORD_W-1:0]    cfg_wdata_i,
  // byte stream in
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [7:0] data_byte
  input  logic                 s_axis_tuser,   // [0] region_start
  // header results out
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // [7:0] tag_octet, [39:8] content_length,
                                               // [71:40] content_offset
  output logic [STATUS_W-1:0]  m_axis_tuser,   // [2:0] status
  output logic                 m_axis_tlast    // region_done
);

  localparam int unsigned LL_W = $clog2(MAX_LENGTH_OCTETS + 1);

  logic [WORD_W-1:0] region_len_q;
  logic              in_valid_q;
  logic [BYTE_W-1:0] in_byte_q;
  logic              in_start_q;
  walk_state_t       st_q, st_d;
  logic [LL_W-1:0]   len_left_q, len_left_d;
  walk_result_t      res_d;
  logic              out_valid_q;
  walk_result_t      out_q;
  logic              adv;

  // Byte in the input register moves on when the result register is free or its result is taken
  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  // Region length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_len_q <= '0;
    end else if (cfg_we_i) begin
      region_len_q <= cfg_wdata_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q  <= s_axis_tdata[BYTE_W-1:0];
      in_start_q <= s_axis_tuser;
    end
  end

  // Per-byte parse
  dtw_step #(
    .MAX_LENGTH_OCTETS(MAX_LENGTH_OCTETS),
    .LL_W             (LL_W)
  ) u_step (
    .state_i        (st_q),
    .len_left_i     (len_left_q),
    .region_length_i(region_len_q),
    .data_byte_i    (in_byte_q),
    .region_start_i (in_start_q),
    .state_o        (st_d),
    .len_left_o     (len_left_d),
    .result_o       (res_d)
  );

  // Walk state; all zero means tag phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= '0;
      len_left_q <= '0;
    end else if (adv) begin
      st_q       <= st_d;
      len_left_q <= len_left_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= res_d.valid;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_d.valid) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.offset, out_q.length, out_q.tag};
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tlast  = out_q.done;

  // Content phase always has bytes left to skip
  a_content_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase == PH_CONTENT |-> st_q.skip_left != '0)
    else $error("content phase with zero skip count");

  // A held error suppresses results until a region start
  a_error_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && st_q.err && !in_start_q |=> !m_axis_tvalid)
    else $error("result emitted while error is held");

  // A good header always points past its own header bytes
  a_ok_offset : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_q.status == ST_OK |-> out_q.offset != '0)
    else $error("good header with zero content offset");

  // A stalled byte stays in the input register
  a_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |=> in_valid_q && $stable(in_byte_q) && $stable(in_start_q))
    else $error("stalled input byte lost");

endmodule
